// ===== sv/dbnv_pkg.sv =====
// Shared types, character codes and character-class helpers for the name validator.
`timescale 1ns / 1ps
`default_nettype none

package dbnv_pkg;

    typedef logic [7:0] t_char;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_IFACE = 2'd1,
        PH_PATH  = 2'd2
    } t_phase;

    localparam t_char CH_NUL    = 8'h00;
    localparam t_char CH_DOT    = 8'h2E;   // '.'
    localparam t_char CH_SLASH  = 8'h2F;   // '/'
    localparam t_char CH_STAR   = 8'h2A;   // '*'
    localparam t_char CH_EQ     = 8'h3D;   // '='
    localparam t_char CH_AT     = 8'h40;   // '@'
    localparam t_char CH_HYPHEN = 8'h2D;   // '-'
    localparam t_char CH_UNDER  = 8'h5F;   // '_'

    localparam logic [1:0] SEG_RESET = 2'd1;
    localparam logic [1:0] SEG_SAT   = 2'd2;

    function automatic logic is_alpha(input t_char c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input t_char c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// ===== sv/dbnv_ch_if.sv =====
// Valid/ready channel carrying one string character per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface dbnv_ch_if import dbnv_pkg::*; ();
    logic  valid;
    logic  ready;
    t_char ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

// ===== sv/dbnv_res_if.sv =====
// Valid/ready channel carrying one pass/fail verdict per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface dbnv_res_if ();
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== sv/dbus_rule_name_validator_top.sv =====
// Top level: input register, validation core, result register and mode register.
//
// Usage:
//   i_in  : one character per transaction; a zero byte terminates the string.
//   o_out : one verdict (valid_res) per terminated string; other characters
//           produce nothing on this channel.
//   i_cfg_we / i_cfg_wdata : writes check_mode (0 = bus name, 1 = call rule).
//           Write only while no string is in flight.
// Throughput: one character per cycle, sustained, as long as o_out keeps up.
// Path: a terminator passes through the input register, then the result register,
//   before its verdict appears on o_out.
// The update of the validation state is a single combinational step per
//   character, between the input register and the state/result registers.
// Reset (synchronous, active low) clears both registers' valid flags, the
//   validation state and check_mode.
// Stall: a held verdict blocks only the next terminator; ordinary characters
//   keep flowing, and i_in.ready drops once a terminator waits in the input
//   register behind an untaken verdict.
`timescale 1ns / 1ps
`default_nettype none

module dbus_rule_name_validator_top import dbnv_pkg::*; #(
    parameter int MAX_PART_LENGTH = 255
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_wdata,
    dbnv_ch_if.sink     i_in,
    dbnv_res_if.source  o_out
);

    logic  r_in_vld;
    t_char r_in_ch;
    logic  r_mode;
    logic  r_out_vld;
    logic  r_out_res;

    logic  term;
    logic  out_free;
    logic  advance;
    logic  core_ok;

    assign term     = (r_in_ch == CH_NUL);
    assign out_free = !r_out_vld || o_out.ready;
    assign advance  = r_in_vld && (!term || out_free);

    assign i_in.ready      = !r_in_vld || advance;
    assign o_out.valid     = r_out_vld;
    assign o_out.valid_res = r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_ch <= i_in.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && term) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && term) begin
            r_out_res <= core_ok;
        end
    end

    dbnv_core #(
        .MAX_PART_LENGTH (MAX_PART_LENGTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_mode  (r_mode),
        .i_ch    (r_in_ch),
        .o_ok    (core_ok)
    );

    // a terminator that leaves the input register always lands a verdict
    a_term_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && term |=> r_out_vld)
        else $error("terminator processed without a verdict");

    // ordinary characters never create a verdict
    a_char_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !term |=> !$rose(r_out_vld))
        else $error("verdict raised by a non-terminator");

    // a character waiting in the input register is neither lost nor changed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in_ch))
        else $error("stalled character dropped or overwritten");

endmodule

`default_nettype wire

// ===== sv/dbnv_core.sv =====
// Per-character validation state and its combinational next-state update.
`timescale 1ns / 1ps
`default_nettype none

module dbnv_core import dbnv_pkg::*; #(
    parameter int MAX_PART_LENGTH = 255
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_mode,
    input  wire t_char i_ch,
    output logic       o_ok
);

    localparam int LW = $clog2(MAX_PART_LENGTH + 2);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PART_LENGTH);
    localparam logic [LW-1:0] LEN_ONE = LW'(1);

    t_phase        r_phase,  n_phase;
    logic [LW-1:0] r_len,    n_len;
    logic [1:0]    r_seg,    n_seg;
    logic          r_inside, n_inside;
    logic          r_wild,   n_wild;
    logic          r_failed, n_failed;

    logic          name_ok;
    logic          path_ok;
    logic          lead;
    logic          clear;
    logic          ok;
    logic [LW-1:0] len_bump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_NAME;
            r_len    <= '0;
            r_seg    <= SEG_RESET;
            r_inside <= 1'b0;
            r_wild   <= 1'b0;
            r_failed <= 1'b0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_seg    <= n_seg;
            r_inside <= n_inside;
            r_wild   <= n_wild;
            r_failed <= n_failed;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_seg    = r_seg;
        n_inside = r_inside;
        n_wild   = r_wild;
        n_failed = r_failed;
        clear    = 1'b0;
        ok       = 1'b0;

        name_ok  = (r_len != '0) && (r_len <= LEN_MAX) &&
                   (r_wild || (r_inside && (r_seg == SEG_SAT)));
        path_ok  = (r_len != '0) && ((r_len == LEN_ONE) || r_wild || r_inside);
        // hyphens are legal only in the bus-name part
        lead     = is_alpha(i_ch) || (i_ch == CH_UNDER) ||
                   ((r_phase == PH_NAME) && (i_ch == CH_HYPHEN));
        len_bump = (r_len <= LEN_MAX) ? r_len + LEN_ONE : r_len;

        if (i_ch == CH_NUL) begin
            unique case (r_phase)
                PH_NAME:  ok = !i_mode && name_ok;
                PH_IFACE: ok = name_ok;
                PH_PATH:  ok = path_ok;
                default:  ok = 1'b0;
            endcase
            ok       = ok && !r_failed;
            n_phase  = PH_NAME;
            n_failed = 1'b0;
            clear    = 1'b1;
        end else begin
            unique case (r_phase)
                PH_NAME, PH_IFACE: begin
                    if (i_mode && (r_phase == PH_NAME) && (i_ch == CH_EQ)) begin
                        if (!name_ok) n_failed = 1'b1;
                        n_phase = PH_IFACE;
                        clear   = 1'b1;
                    end else if (i_mode && (r_phase == PH_IFACE) && (i_ch == CH_AT)) begin
                        // empty interface is fine before '@'
                        if (r_len > LEN_MAX) n_failed = 1'b1;
                        else if ((r_len != '0) && !name_ok) n_failed = 1'b1;
                        n_phase = PH_PATH;
                        clear   = 1'b1;
                    end else begin
                        n_len = len_bump;
                        if (r_wild) begin
                            n_failed = 1'b1;
                        end else if (!r_inside) begin
                            if (i_ch == CH_STAR) n_wild = 1'b1;
                            else if (!lead) n_failed = 1'b1;
                            n_inside = 1'b1;
                        end else if (i_ch == CH_DOT) begin
                            if (r_seg < SEG_SAT) n_seg = r_seg + 2'd1;
                            n_inside = 1'b0;
                        end else if (!lead && !is_digit(i_ch)) begin
                            n_failed = 1'b1;
                        end
                    end
                end
                PH_PATH: begin
                    n_len = len_bump;
                    if (r_len == '0) begin
                        if (i_ch != CH_SLASH) n_failed = 1'b1;
                    end else if (r_wild) begin
                        n_failed = 1'b1;
                    end else if (!r_inside) begin
                        if (i_ch == CH_STAR) n_wild = 1'b1;
                        else if (!is_alpha(i_ch) && (i_ch != CH_UNDER)) n_failed = 1'b1;
                        n_inside = 1'b1;
                    end else if (i_ch == CH_SLASH) begin
                        n_inside = 1'b0;
                    end else if (!is_alpha(i_ch) && !is_digit(i_ch) && (i_ch != CH_UNDER)) begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_NAME;
                    clear   = 1'b1;
                end
            endcase
        end

        if (clear) begin
            n_len    = '0;
            n_seg    = SEG_RESET;
            n_inside = 1'b0;
            n_wild   = 1'b0;
        end
    end

    assign o_ok = ok;

endmodule

`default_nettype wire
